[rtl/range_average_and_speed_assert.svh]
// Assertion macros for the range averaging block's checker.
`ifndef RANGE_AVERAGE_AND_SPEED_ASSERT_SVH
`define RANGE_AVERAGE_AND_SPEED_ASSERT_SVH

// Same-cycle implication, sampled on clock and dropped while reset is high.
`define RAS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and dropped while reset is high.
`define RAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ras_pkg.sv]
// Shared widths, constants and controller types of the range averaging block.
`default_nettype none

package ras_pkg;

   localparam int RANGE_W   = 13;
   localparam int STATUS_W  = 8;
   localparam int ELAPSED_W = 16;
   localparam int SCALE_W   = 10;
   localparam int SPEED_W   = 27;
   localparam int FRAC_W    = 4;
   localparam int RANGE_MAX = 8191;

   localparam logic [STATUS_W-1:0] INVALID_STATUS = 8'd4;
   localparam logic [SCALE_W-1:0]  SCALE_RESET    = 10'd100;
   localparam logic [SPEED_W-1:0]  SPEED_MAX      = 27'd131056000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic accum;
      logic mean;
      logic launch;
      logic emit;
   } ras_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic sum_last;
      logic div_done;
      logic out_free;
   } ras_status_type;

endpackage

`default_nettype wire

[rtl/ras_req_if.sv]
// Request channel: one range sample with its status and elapsed time.
`default_nettype none

interface ras_req_if;
   logic                         valid;
   logic                         ready;
   logic [ras_pkg::RANGE_W-1:0]  range_mm;
   logic [ras_pkg::STATUS_W-1:0] range_status;
   logic [ras_pkg::ELAPSED_W-1:0] elapsed_ms;

   modport source (output valid, range_mm, range_status, elapsed_ms, input ready);
   modport sink (input valid, range_mm, range_status, elapsed_ms, output ready);
endinterface

`default_nettype wire

[rtl/ras_rsp_if.sv]
// Response channel: averaged range and speed estimate.
`default_nettype none

interface ras_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ras_pkg::RANGE_W-1:0] average_mm;
   logic [ras_pkg::SPEED_W-1:0] speed_q4;
   logic                        speed_saturated;

   modport source (output valid, average_mm, speed_q4, speed_saturated, input ready);
   modport sink (input valid, average_mm, speed_q4, speed_saturated, output ready);
endinterface

`default_nettype wire

[rtl/range_average_and_speed.sv]
// Top level of the range averaging and speed estimation block.
//
// Each request beat carries one range sample; a sample whose status is 4 is not stored,
// any other is written into a ring of DEPTH entries that reset clears at once. Every
// request yields one response beat: the truncated mean of the whole ring, and the speed
// |mean - previous mean| * speed_scale * 16 / elapsed_ms, truncated, with 4 fraction bits.
// The speed is capped at SPEED_MAX; a zero elapsed time forces it to SPEED_MAX and raises
// speed_saturated. One request is in work at a time: the ring is summed through one adder,
// the mean is taken by a reciprocal multiply, the change is multiplied by the scale and
// launched into the bit-serial divider, the response register is loaded once the output
// is free, and the controller goes back to idle to take the next request. The finished
// response waits in an output register, so a new request is taken while it is still
// unread. speed_scale is written through csr_wr_en and csr_wr_data while the block is
// idle; the user is bound to this, and the block itself does not enforce it.
`default_nettype none

module range_average_and_speed #(
   parameter int DEPTH = 7
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   ras_req_if.sink                           req_ch,
   ras_rsp_if.source                         rsp_ch,
   input  wire logic                         csr_wr_en,
   input  wire logic [ras_pkg::SCALE_W-1:0]  csr_wr_data
);

   ras_pkg::ras_cmd_type    cmd;
   ras_pkg::ras_status_type status;

   ras_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ras_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .range_mm        (req_ch.range_mm),
      .range_status    (req_ch.range_status),
      .elapsed_ms      (req_ch.elapsed_ms),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .average_mm      (rsp_ch.average_mm),
      .speed_q4        (rsp_ch.speed_q4),
      .speed_saturated (rsp_ch.speed_saturated)
   );

endmodule

`default_nettype wire

[rtl/ras_divider.sv]
// Bit-serial restoring divider for the speed quotient, one quotient bit per cycle.
`default_nettype none

module ras_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ras_pkg::SPEED_W-1:0]   dividend,
   input  wire logic [ras_pkg::ELAPSED_W-1:0] divisor,
   output logic      [ras_pkg::SPEED_W-1:0]   quotient,
   output logic                               done
);

   localparam int NUM_W = ras_pkg::SPEED_W;
   localparam int DEN_W = ras_pkg::ELAPSED_W;
   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   // The partial remainder stays below the divisor, so one extra bit holds the shifted value.
   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign fits      = (rem_shift >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

[rtl/ras_datapath.sv]
// Datapath: sample ring, running sum, mean, scaled change, divider and result register.
`default_nettype none

module ras_datapath #(
   parameter int DEPTH = 7
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ras_pkg::ras_cmd_type           cmd,
   output ras_pkg::ras_status_type             status,
   input  wire logic [ras_pkg::RANGE_W-1:0]    range_mm,
   input  wire logic [ras_pkg::STATUS_W-1:0]   range_status,
   input  wire logic [ras_pkg::ELAPSED_W-1:0]  elapsed_ms,
   input  wire logic                           csr_wr_en,
   input  wire logic [ras_pkg::SCALE_W-1:0]    csr_wr_data,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output logic      [ras_pkg::RANGE_W-1:0]    average_mm,
   output logic      [ras_pkg::SPEED_W-1:0]    speed_q4,
   output logic                                speed_saturated
);

   localparam int RANGE_W  = ras_pkg::RANGE_W;
   localparam int SCALE_W  = ras_pkg::SCALE_W;
   localparam int SPEED_W  = ras_pkg::SPEED_W;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W    = $clog2(DEPTH * ras_pkg::RANGE_MAX + 1);
   // Reciprocal of DEPTH, exact for every sum below 2**SUM_W since DEPTH stays under 2**4.
   localparam int RECIP_SH = SUM_W + 4;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**RECIP_SH + DEPTH - 1) / DEPTH);
   localparam int MAG_W    = RANGE_W + SCALE_W;

   logic [RANGE_W-1:0]              ring_ff [DEPTH];
   logic [IDX_W-1:0]                slot_ff;
   logic [IDX_W-1:0]                idx_ff;
   logic [SUM_W-1:0]                acc_ff;
   logic [ras_pkg::ELAPSED_W-1:0]   elapsed_ff;
   logic [RANGE_W-1:0]              mean_ff;
   logic [RANGE_W-1:0]              prev_ff;
   logic [SCALE_W-1:0]              scale_ff;
   logic                            rsp_valid_ff;
   logic [RANGE_W-1:0]              average_ff;
   logic [SPEED_W-1:0]              speed_ff;
   logic                            sat_ff;

   logic [IDX_W-1:0]                slot_in;
   logic [PROD_W-1:0]               mean_prod;
   logic [RANGE_W-1:0]              mean_in;
   logic [RANGE_W-1:0]              change;
   logic [MAG_W-1:0]                mag_prod;
   logic [SPEED_W-1:0]              dividend;
   logic [SPEED_W-1:0]              quotient;
   logic                            div_done;
   logic [SPEED_W-1:0]              speed_in;
   logic                            sample_ok;

   assign sample_ok = (range_status != ras_pkg::INVALID_STATUS);
   assign slot_in   = (slot_ff == IDX_W'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   assign mean_prod = PROD_W'(acc_ff) * PROD_W'(RECIP);
   assign mean_in   = mean_prod[RECIP_SH +: RANGE_W];

   assign change    = (mean_ff >= prev_ff) ? (mean_ff - prev_ff) : (prev_ff - mean_ff);
   assign mag_prod  = MAG_W'(change) * MAG_W'(scale_ff);
   assign dividend  = SPEED_W'({mag_prod, {ras_pkg::FRAC_W{1'b0}}});

   // Only a scale above 1000, or a zero elapsed time, can push the quotient past the top of the range.
   assign speed_in  = (quotient > ras_pkg::SPEED_MAX) ? ras_pkg::SPEED_MAX : quotient;

   ras_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.launch),
      .dividend (dividend),
      .divisor  (elapsed_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   // State that the block's reset defines.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         slot_ff      <= '0;
         prev_ff      <= '0;
         scale_ff     <= ras_pkg::SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
         if (cmd.load && sample_ok) begin
            ring_ff[slot_ff] <= range_mm;
            slot_ff          <= slot_in;
         end
         if (cmd.launch) begin
            prev_ff <= mean_ff;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and the result register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff     <= '0;
         idx_ff     <= '0;
         elapsed_ff <= elapsed_ms;
      end else if (cmd.accum) begin
         acc_ff <= acc_ff + SUM_W'(ring_ff[idx_ff]);
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.mean) begin
         mean_ff <= mean_in;
      end
      if (cmd.emit) begin
         average_ff <= mean_ff;
         if (elapsed_ff == '0) begin
            speed_ff <= ras_pkg::SPEED_MAX;
            sat_ff   <= 1'b1;
         end else begin
            speed_ff <= speed_in;
            sat_ff   <= 1'b0;
         end
      end
   end

   assign status.sum_last = (idx_ff == IDX_W'(DEPTH - 1));
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign average_mm      = average_ff;
   assign speed_q4        = speed_ff;
   assign speed_saturated = sat_ff;

endmodule

`default_nettype wire

[rtl/ras_ctrl.sv]
// Controller: sequences accept, ring sum, mean, divider launch and result load.
`default_nettype none

module ras_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output ras_pkg::ras_cmd_type         cmd,
   input  wire ras_pkg::ras_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MEAN,
      ST_LAUNCH,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               if (status.sum_last) begin
                  state_ff <= ST_MEAN;
               end
            end
            ST_MEAN: begin
               state_ff <= ST_LAUNCH;
            end
            ST_LAUNCH: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (status.div_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.accum  = (state_ff == ST_SUM);
      cmd.mean   = (state_ff == ST_MEAN);
      cmd.launch = (state_ff == ST_LAUNCH);
      cmd.emit   = (state_ff == ST_EMIT) && status.out_free;
   end

endmodule

`default_nettype wire

[rtl/ras_checker.sv]
// Port-level checker for the range averaging block and its bind to the top level.
`default_nettype none

`include "range_average_and_speed_assert.svh"

module ras_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [ras_pkg::SPEED_W-1:0] speed_q4,
   input wire logic                        speed_saturated
);

   // A response beat that is not taken stays offered.
   `RAS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped before it was taken")

   // A saturated speed always reads as the top of the range.
   `RAS_ASSERT_NOW(a_sat_max, rsp_valid && speed_saturated, speed_q4 == ras_pkg::SPEED_MAX, "saturated speed is not at its maximum")

   // A taken request drops req_ready; the design takes no further request until its result is loaded.
   `RAS_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready, "second request taken while one is in work")

   // A new response appears exactly as the block becomes free for the next request.
   `RAS_ASSERT_NOW(a_rsp_frees_req, $rose(rsp_valid), req_ready, "response loaded while the controller is still busy")

endmodule

bind range_average_and_speed ras_checker u_ras_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .speed_q4        (rsp_ch.speed_q4),
   .speed_saturated (rsp_ch.speed_saturated)
);

`default_nettype wire

[tb/range_average_and_speed_tb.sv]
// Self-checking testbench for the range averaging and speed estimation block.
`default_nettype none

module range_average_and_speed_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANGE_W   = ras_pkg::RANGE_W;
   localparam int STATUS_W  = ras_pkg::STATUS_W;
   localparam int ELAPSED_W = ras_pkg::ELAPSED_W;
   localparam int SCALE_W   = ras_pkg::SCALE_W;
   localparam int SPEED_W   = ras_pkg::SPEED_W;
   localparam int RANGE_MAX = ras_pkg::RANGE_MAX;

   localparam int RING_DEPTH     = 7;
   localparam int LONG_STALL     = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_PAD      = 8;
   localparam int TAIL_CYCLES    = 80;

   typedef struct packed {
      logic [RANGE_W-1:0]   range_mm;
      logic [STATUS_W-1:0]  range_status;
      logic [ELAPSED_W-1:0] elapsed_ms;
   } range_sample_type;

   typedef struct packed {
      logic [RANGE_W-1:0] average_mm;
      logic [SPEED_W-1:0] speed_q4;
      logic               speed_saturated;
   } range_result_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [SCALE_W-1:0] csr_wr_data;

   ras_req_if req_bus ();
   ras_rsp_if rsp_bus ();

   range_average_and_speed #(
      .DEPTH (RING_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   range_sample_type pending_samples[$];
   range_result_type expected_results[$];

   // Mirror of the block's state.
   logic [RANGE_W-1:0] ring_mm [RING_DEPTH];
   int                 slot_model;
   logic [RANGE_W-1:0] last_mean;
   logic [SCALE_W-1:0] scale_model;

   int send_idle_pct = 8;
   int recv_idle_pct = 71;
   bit long_stall_on = 1'b0;
   int stall_count;
   int quiet_cycles;
   int fail_count = 0;
   int track_mm = 4000;

   function automatic range_result_type average_and_speed(input range_sample_type s);
      range_result_type   r;
      int unsigned        total;
      logic [RANGE_W-1:0] mean;
      logic [RANGE_W-1:0] delta;
      longint unsigned    num;
      if (s.range_status != ras_pkg::INVALID_STATUS) begin
         ring_mm[slot_model] = s.range_mm;
         slot_model = (slot_model == RING_DEPTH - 1) ? 0 : slot_model + 1;
      end
      total = 0;
      for (int i = 0; i < RING_DEPTH; i++) total += ring_mm[i];
      mean = RANGE_W'(total / RING_DEPTH);
      delta = (mean >= last_mean) ? mean - last_mean : last_mean - mean;
      if (s.elapsed_ms == '0) begin
         r.speed_q4 = ras_pkg::SPEED_MAX;
         r.speed_saturated = 1'b1;
      end else begin
         num = longint'(delta) * longint'(scale_model) * 16 / longint'(s.elapsed_ms);
         r.speed_q4 = (num > longint'(ras_pkg::SPEED_MAX)) ? ras_pkg::SPEED_MAX
                                                           : SPEED_W'(num);
         r.speed_saturated = 1'b0;
      end
      r.average_mm = mean;
      last_mean = mean;
      return r;
   endfunction

   function automatic range_sample_type make_sample();
      range_sample_type s;
      int unsigned      kind;
      kind = $urandom_range(99);
      if (kind < 70) begin
         // A target drifting in front of the sensor, sampled at varying intervals.
         track_mm += int'($urandom_range(600)) - 300;
         if (track_mm < 0) track_mm = 0;
         if (track_mm > RANGE_MAX) track_mm = RANGE_MAX;
         s.range_mm = RANGE_W'(track_mm);
         s.range_status = ($urandom_range(9) < 8) ? '0 : STATUS_W'($urandom);
         s.elapsed_ms = ELAPSED_W'($urandom_range(120, 10));
      end else if (kind < 80) begin
         s.range_mm = RANGE_W'($urandom);
         s.range_status = ras_pkg::INVALID_STATUS;
         s.elapsed_ms = ELAPSED_W'($urandom);
      end else if (kind < 85) begin
         s.range_mm = RANGE_W'($urandom);
         s.range_status = STATUS_W'($urandom);
         s.elapsed_ms = '0;
      end else if (kind < 90) begin
         s.range_mm = ($urandom_range(1) == 0) ? '0 : RANGE_W'(RANGE_MAX);
         s.range_status = '0;
         s.elapsed_ms = ELAPSED_W'($urandom_range(3, 1));
      end else begin
         s.range_mm = RANGE_W'($urandom);
         s.range_status = STATUS_W'($urandom);
         s.elapsed_ms = ELAPSED_W'($urandom);
      end
      return s;
   endfunction

   task automatic queue_sample(input int range_mm, input int status, input int elapsed);
      range_sample_type s;
      s.range_mm = RANGE_W'(range_mm);
      s.range_status = STATUS_W'(status);
      s.elapsed_ms = ELAPSED_W'(elapsed);
      pending_samples.push_back(s);
   endtask

   task automatic queue_random(input int count);
      repeat (count) pending_samples.push_back(make_sample());
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic set_speed_scale(input logic [SCALE_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      scale_model = value;
   endtask

   // Request driver: holds a beat until it is taken, then offers the next one or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(average_and_speed(pending_samples.pop_front()));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.range_mm <= pending_samples[0].range_mm;
               req_bus.range_status <= pending_samples[0].range_status;
               req_bus.elapsed_ms <= pending_samples[0].elapsed_ms;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response receiver, with one long hold-off so the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_count <= 0;
      end else if (long_stall_on && stall_count < LONG_STALL) begin
         rsp_bus.ready <= 1'b0;
         stall_count <= stall_count + 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      range_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("response beat with no request waiting for it");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.average_mm !== want.average_mm) begin
               $error("average_mm: expected %0d, actual %0d", want.average_mm,
                      rsp_bus.average_mm);
               fail_count++;
            end
            if (rsp_bus.speed_q4 !== want.speed_q4) begin
               $error("speed_q4: expected %0d, actual %0d", want.speed_q4, rsp_bus.speed_q4);
               fail_count++;
            end
            if (rsp_bus.speed_saturated !== want.speed_saturated) begin
               $error("speed_saturated: expected %0d, actual %0d", want.speed_saturated,
                      rsp_bus.speed_saturated);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.range_mm = '0;
      req_bus.range_status = '0;
      req_bus.elapsed_ms = '0;
      rsp_bus.ready = 1'b0;
      quiet_cycles = 0;
      for (int i = 0; i < RING_DEPTH; i++) ring_mm[i] = '0;
      slot_model = 0;
      last_mean = '0;
      scale_model = ras_pkg::SCALE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset scale: zero elapsed time with an unchanged mean,
      // full-scale ranges filling the ring, invalid samples and extreme status codes.
      queue_sample(0, 0, 0);
      queue_sample(RANGE_MAX, 0, 1);
      queue_sample(RANGE_MAX, ras_pkg::INVALID_STATUS, 65535);
      queue_sample(RANGE_MAX, 255, 65535);
      repeat (6) queue_sample(RANGE_MAX, 0, 1);
      queue_sample(RANGE_MAX, 3, 0);
      queue_sample(0, ras_pkg::INVALID_STATUS, 0);
      queue_sample(0, 5, 1);
      queue_sample(0, 0, 65535);
      queue_sample(4096, 1, 100);
      queue_sample(0, ras_pkg::INVALID_STATUS, 1);
      queue_sample(8190, 128, 2);
      queue_sample(1, 127, 32768);
      wait_drained();

      set_speed_scale(10'd1000);
      queue_sample(RANGE_MAX, 0, 1);
      queue_sample(0, 0, 1);
      queue_sample(0, 0, 0);
      wait_drained();

      // Sender rarely idles and the receiver mostly does; the long hold-off falls here.
      send_idle_pct = 8;
      recv_idle_pct = 71;
      queue_random(300);
      long_stall_on = 1'b1;
      wait_drained();

      set_speed_scale(10'd1);
      queue_random(250);
      wait_drained();

      send_idle_pct = 71;
      recv_idle_pct = 8;
      set_speed_scale(10'd0);
      queue_sample(RANGE_MAX, 0, 1);
      queue_sample(0, 0, 0);
      queue_random(100);
      wait_drained();

      set_speed_scale(10'd1023);
      queue_random(250);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_speed_scale(SCALE_W'($urandom));
      queue_random(300);
      wait_drained();

      set_speed_scale(SCALE_W'($urandom));
      queue_random(377);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d responses never arrived", expected_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/ras_pkg.sv
rtl/ras_req_if.sv
rtl/ras_rsp_if.sv
rtl/ras_divider.sv
rtl/ras_datapath.sv
rtl/ras_ctrl.sv
rtl/range_average_and_speed.sv
rtl/ras_checker.sv
tb/range_average_and_speed_tb.sv
